/* rtl/core/dsc_pkg.sv */
// Shared constants, codes and the step-rate table of the delta sample channel.
package dsc_pkg;

  // Bits shifted out per sample byte
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitsW       = $clog2(BitsPerByte + 1);

  // Payload widths
  localparam int unsigned LevelW  = 7;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned LenW    = 12;
  localparam int unsigned PeriodW = 9;
  localparam int unsigned StatusW = 2;

  // Stream widths: tuser carries {reg_sel, mode}, tdata the byte
  localparam int unsigned InUserW  = 5;
  localparam int unsigned InDataW  = 8;
  // Result: tdata {status_bits, fetch_addr, irq, level} padded to 32, tuser fetch_req
  localparam int unsigned OutDataW = 32;

  // Request kinds
  localparam logic [1:0] ModeTick   = 2'd0;
  localparam logic [1:0] ModeWrite  = 2'd1;
  localparam logic [1:0] ModeByte   = 2'd2;
  localparam logic [1:0] ModeStatus = 2'd3;

  // Register write targets
  localparam logic [2:0] RegRate   = 3'd0;
  localparam logic [2:0] RegLevel  = 3'd1;
  localparam logic [2:0] RegStart  = 3'd2;
  localparam logic [2:0] RegLength = 3'd3;
  localparam logic [2:0] RegEnable = 3'd4;

  // Address and level constants
  localparam logic [AddrW-1:0]  AddrReset = 16'hC000;
  localparam logic [LevelW-1:0] LevelTop  = 7'd125;
  localparam logic [LevelW-1:0] LevelStep = 7'd2;

  // Step period, in unit cycles, for each rate index
  function automatic logic [PeriodW-1:0] rate_period(input logic [3:0] idx);
    logic [PeriodW-1:0] p;
    case (idx)
      4'd0:    p = 9'd428;
      4'd1:    p = 9'd380;
      4'd2:    p = 9'd340;
      4'd3:    p = 9'd320;
      4'd4:    p = 9'd286;
      4'd5:    p = 9'd254;
      4'd6:    p = 9'd226;
      4'd7:    p = 9'd214;
      4'd8:    p = 9'd190;
      4'd9:    p = 9'd160;
      4'd10:   p = 9'd142;
      4'd11:   p = 9'd128;
      4'd12:   p = 9'd106;
      4'd13:   p = 9'd84;
      4'd14:   p = 9'd72;
      4'd15:   p = 9'd54;
      default: p = 9'd428;
    endcase
    return p;
  endfunction

endpackage

/* rtl/core/delta_sample_channel.sv */
// Top level of the 1-bit delta sample playback channel.
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  ---------+-----+--------------------------------------------+-------------------
//  s_axis   | in  | data_byte[7:0]                             | mode[1:0], reg_sel[4:2]
//  m_axis   | out | level[6:0], irq[7], fetch_addr[23:8],      | fetch_req[0]
//           |     | status_bits[25:24], zero[31:26]            |
//
// One request per cycle is accepted while the result is not stalled; its result passes through
// the input register, then the result register. The channel state updates in the cycle a
// request moves from the input register into the result register.
// Reset clears all control state and the channel registers but the byte buffer to their idle values.
// A stalled result holds the result register; the input register still takes one
// more request, and the input side stalls once both registers are full.
module delta_sample_channel
  import dsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic [InUserW-1:0]  s_axis_tuser,   // mode[1:0], reg_sel[4:2]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // level, irq, fetch_addr, status_bits
  output logic                m_axis_tuser    // fetch_req
);

  // Input register
  logic               in_vld_q;
  logic [1:0]         mode_q;
  logic [2:0]         sel_q;
  logic [7:0]         byte_q;

  // Result register
  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                out_req_q, out_req_d;

  // Channel state
  logic [LevelW-1:0]  level_q, level_d;
  logic [7:0]         shifter_q, shifter_d;
  logic [BitsW-1:0]   bits_q, bits_d;
  logic [7:0]         buffer_q, buffer_d;
  logic               empty_q, empty_d;
  logic               silent_q, silent_d;
  logic               pending_q, pending_d;
  logic [AddrW-1:0]   cur_addr_q, cur_addr_d;
  logic [LenW-1:0]    left_q, left_d;
  logic [AddrW-1:0]   start_q, start_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [PeriodW-1:0] count_q, count_d;
  logic               loop_q, loop_d;
  logic               irq_en_q, irq_en_d;
  logic               irq_q, irq_d;
  logic               enable_q, enable_d;

  logic               advance;
  logic               step;
  logic               try_fetch;
  logic               clr_irq;
  logic               fetch;
  logic [AddrW-1:0]   fetch_addr;
  logic [StatusW-1:0] status;
  logic [AddrW-1:0]   addr_inc;

  // Move the input register forward whenever the result register is free
  assign advance       = ~out_vld_q | m_axis_tready;
  assign step          = in_vld_q & advance;
  assign s_axis_tready = ~in_vld_q | advance;

  // Process one request against the channel state
  always_comb begin
    level_d    = level_q;
    shifter_d  = shifter_q;
    bits_d     = bits_q;
    buffer_d   = buffer_q;
    empty_d    = empty_q;
    silent_d   = silent_q;
    pending_d  = pending_q;
    cur_addr_d = cur_addr_q;
    left_d     = left_q;
    start_d    = start_q;
    len_d      = len_q;
    period_d   = period_q;
    count_d    = count_q;
    loop_d     = loop_q;
    irq_en_d   = irq_en_q;
    irq_d      = irq_q;
    enable_d   = enable_q;
    try_fetch  = 1'b0;
    clr_irq    = 1'b0;
    fetch      = 1'b0;
    fetch_addr = cur_addr_q;
    status     = '0;
    addr_inc   = '0;

    case (mode_q)
      ModeTick: begin
        if (count_q > PeriodW'(1)) begin
          count_d = count_q - PeriodW'(1);
        end else begin
          count_d = period_q;
          // Step the level, drop a step that would leave the range
          if (!silent_q) begin
            if (shifter_q[0]) begin
              if (level_q <= LevelTop) level_d = level_q + LevelStep;
            end else begin
              if (level_q >= LevelStep) level_d = level_q - LevelStep;
            end
          end
          shifter_d = {1'b0, shifter_q[7:1]};
          bits_d    = bits_q - BitsW'(1);
          if (bits_d == '0) begin
            bits_d = BitsW'(BitsPerByte);
            if (empty_q) begin
              silent_d = 1'b1;
            end else begin
              silent_d  = 1'b0;
              shifter_d = buffer_q;
              empty_d   = 1'b1;
              try_fetch = 1'b1;
            end
          end
        end
      end
      ModeWrite: begin
        case (sel_q)
          RegRate: begin
            period_d = rate_period(byte_q[3:0]);
            loop_d   = byte_q[6];
            irq_en_d = byte_q[7];
            if (!byte_q[7]) irq_d = 1'b0;
          end
          RegLevel: begin
            level_d = byte_q[LevelW-1:0];
          end
          RegStart: begin
            start_d = {2'b11, byte_q, 6'b0};
          end
          RegLength: begin
            len_d = {byte_q, 4'b0001};
          end
          RegEnable: begin
            enable_d = byte_q[4];
            if (byte_q[4]) begin
              if (left_q == '0) begin
                cur_addr_d = start_q;
                left_d     = len_q;
              end
              try_fetch = 1'b1;
            end else begin
              left_d    = '0;
              empty_d   = 1'b1;
              pending_d = 1'b0;
            end
            clr_irq = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ModeByte: begin
        // Ignore a byte nobody asked for
        if (pending_q) begin
          pending_d = 1'b0;
          buffer_d  = byte_q;
          empty_d   = 1'b0;
        end
      end
      default: begin
        status = {irq_q, left_q != '0};
      end
    endcase

    // Issue a byte fetch when the buffer is free and bytes remain
    if (try_fetch && empty_d && !pending_d && left_d != '0) begin
      fetch      = 1'b1;
      fetch_addr = cur_addr_d;
      pending_d  = 1'b1;
      addr_inc   = cur_addr_d + AddrW'(1);
      cur_addr_d = {1'b1, addr_inc[AddrW-2:0]};
      left_d     = left_d - LenW'(1);
      if (left_d == '0) begin
        if (loop_d) begin
          cur_addr_d = start_d;
          left_d     = len_d;
        end else if (irq_en_d) begin
          irq_d = 1'b1;
        end
      end
    end

    // An enable write drops the flag, even one its own fetch just raised
    if (clr_irq) irq_d = 1'b0;

    out_req_d  = fetch;
    out_data_d = {6'b0, status, (fetch ? fetch_addr : cur_addr_d), irq_d, level_d};
  end

  // Control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      level_q    <= '0;
      shifter_q  <= '0;
      bits_q     <= BitsW'(BitsPerByte);
      empty_q    <= 1'b1;
      silent_q   <= 1'b1;
      pending_q  <= 1'b0;
      cur_addr_q <= AddrReset;
      left_q     <= '0;
      start_q    <= AddrReset;
      len_q      <= LenW'(1);
      period_q   <= rate_period(4'd0);
      count_q    <= rate_period(4'd0);
      loop_q     <= 1'b0;
      irq_en_q   <= 1'b0;
      irq_q      <= 1'b0;
      enable_q   <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (advance)       out_vld_q <= in_vld_q;
      if (step) begin
        level_q    <= level_d;
        shifter_q  <= shifter_d;
        bits_q     <= bits_d;
        empty_q    <= empty_d;
        silent_q   <= silent_d;
        pending_q  <= pending_d;
        cur_addr_q <= cur_addr_d;
        left_q     <= left_d;
        start_q    <= start_d;
        len_q      <= len_d;
        period_q   <= period_d;
        count_q    <= count_d;
        loop_q     <= loop_d;
        irq_en_q   <= irq_en_d;
        irq_q      <= irq_d;
        enable_q   <= enable_d;
      end
    end
  end

  // Payload registers: request fields, byte buffer and result
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mode_q <= s_axis_tuser[1:0];
      sel_q  <= s_axis_tuser[4:2];
      byte_q <= s_axis_tdata;
    end
    if (step) begin
      buffer_q   <= buffer_d;
      out_data_q <= out_data_d;
      out_req_q  <= out_req_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_req_q;

endmodule

/* rtl/core/dsc_checker.sv */
// Port-level checks of the delta sample channel, bound to its top level.
module dsc_checker
  import dsc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // No result shows while reset is held
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // An accepted request has a result showing once it has passed the input and result registers
  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("accepted request produced no result");

  // Fetches always target the upper half of the address space
  a_fetch_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23])
    else $error("fetch address below the sample area");

  // Status interrupt bit agrees with the interrupt flag
  a_status_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[7])
    else $error("status interrupt bit disagrees with irq");

endmodule

bind delta_sample_channel dsc_checker u_dsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
